// ===== hw/rtl/odpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// odpc_pkg
// Types and constants shared by the ordinal date to calendar converter.
// ----------------------------------------------------------------------------
package odpc_pkg;

   localparam int CHAR_W   = 8;
   localparam int PRES_W   = 3;
   localparam int CYEAR_W  = 7;
   localparam int STATUS_W = 2;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DOM_W    = 5;
   localparam int DOY_W    = 10;
   localparam int YY_W     = 9;

   localparam int NUM_MONTHS = 12;

   // Register byte addresses
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_CURRENT_YEAR = 1'b0;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [PRES_W-1:0] FULL_CODE_LEN = 3'd4;

   localparam logic [YEAR_W-1:0] CENTURY_19 = 12'd1900;
   localparam logic [YEAR_W-1:0] CENTURY_20 = 12'd2000;
   localparam logic signed [YY_W-1:0] PIVOT_YY = 9'sd70;

   localparam logic [DOY_W-1:0] DAYS_COMMON_YEAR = 10'd365;

   // Last day of year of months January through November, common year
   localparam logic [DOY_W-1:0] MONTH_END [NUM_MONTHS-1] = '{
      10'd31, 10'd59, 10'd90, 10'd120, 10'd151, 10'd181,
      10'd212, 10'd243, 10'd273, 10'd304, 10'd334
   };

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_DAY    = 2'd2
   } status_type;

   typedef struct packed {
      status_type                status;
      logic [YEAR_W-1:0]         cal_year;
      logic [MONTH_W-1:0]        month_number;
      logic [DOM_W-1:0]          day_of_month;
   } result_type;

   typedef struct packed {
      logic [PRES_W-1:0] chars_present;
      logic [CHAR_W-1:0] year_digit_char;
      logic [CHAR_W-1:0] day_hundreds_char;
      logic [CHAR_W-1:0] day_tens_char;
      logic [CHAR_W-1:0] day_ones_char;
   } code_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ordinal_date_pivot_to_calendar.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordinal_date_pivot_to_calendar
// Converts a YDDD ordinal code to a calendar date using a decade pivot on
// the configured two-digit current year.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  req      req_valid / req_ready     chars_present, four ASCII code characters
//  rsp      rsp_valid / rsp_ready     status, full_year, month_number, day_of_month
//  csr      APB psel/penable/pwrite   current_year_two_digit at byte address 0
//
//  One transaction per cycle while the response side is not stalled; a code
//  passes the input register, then the result register, with the decode between them.
//  A stalled result holds; the input register still takes a new code while
//  the result register waits, then the input side stalls.
//  Synchronous reset empties both stages and clears the current year to 0.
// ----------------------------------------------------------------------------
module ordinal_date_pivot_to_calendar (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,

   input  wire  logic                                  req_valid,
   output       logic                                  req_ready,
   input  wire  logic [odpc_pkg::PRES_W-1:0]           req_chars_present,
   input  wire  logic [odpc_pkg::CHAR_W-1:0]           req_year_digit_char,
   input  wire  logic [odpc_pkg::CHAR_W-1:0]           req_day_hundreds_char,
   input  wire  logic [odpc_pkg::CHAR_W-1:0]           req_day_tens_char,
   input  wire  logic [odpc_pkg::CHAR_W-1:0]           req_day_ones_char,

   output       logic                                  rsp_valid,
   input  wire  logic                                  rsp_ready,
   output       logic [odpc_pkg::STATUS_W-1:0]         rsp_status,
   output       logic [odpc_pkg::YEAR_W-1:0]           rsp_full_year,
   output       logic [odpc_pkg::MONTH_W-1:0]          rsp_month_number,
   output       logic [odpc_pkg::DOM_W-1:0]            rsp_day_of_month,

   input  wire  logic                                  psel,
   input  wire  logic                                  penable,
   input  wire  logic                                  pwrite,
   input  wire  logic [odpc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  logic [31:0]                           pwdata,
   output       logic [31:0]                           prdata,
   output       logic                                  pready
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   odpc_pkg::code_type                code_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   odpc_pkg::result_type              result_ff;
   odpc_pkg::result_type              result_next;
   logic [odpc_pkg::CYEAR_W-1:0]      cyear_ff;
   logic                              advance;
   logic                              csr_write;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   assign csr_write = psel && penable && pwrite &&
                      (paddr[2] == odpc_pkg::REG_CURRENT_YEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cyear_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            cyear_ff <= pwdata[odpc_pkg::CYEAR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         code_ff <= '{req_chars_present, req_year_digit_char, req_day_hundreds_char,
                      req_day_tens_char, req_day_ones_char};
      end
      // advance the decoded code into the result register
      if (advance && in_valid_ff) begin
         result_ff <= result_next;
      end
   end

   odpc_convert u_convert (
      .code         (code_ff),
      .cyear        (cyear_ff),
      .result       (result_next)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = result_ff.status;
   assign rsp_full_year    = result_ff.cal_year;
   assign rsp_month_number = result_ff.month_number;
   assign rsp_day_of_month = result_ff.day_of_month;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == odpc_pkg::REG_CURRENT_YEAR) ?
                   {{(32 - odpc_pkg::CYEAR_W){1'b0}}, cyear_ff} : 32'd0;

endmodule
`default_nettype wire

// ===== hw/rtl/odpc_convert.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// odpc_convert
// Decodes one YDDD code against the current year into year, month and day.
// ----------------------------------------------------------------------------
module odpc_convert (
   input  wire odpc_pkg::code_type                  code,
   input  wire logic [odpc_pkg::CYEAR_W-1:0]        cyear,
   output      odpc_pkg::result_type                result
);

   logic                                 format_bad;
   logic [3:0]                           d;
   logic [3:0]                           t;
   logic [3:0]                           q;
   logic [13:0]                          prod;
   logic signed [odpc_pkg::YY_W-1:0]     c_s;
   logic signed [odpc_pkg::YY_W-1:0]     d_s;
   logic signed [odpc_pkg::YY_W-1:0]     t_s;
   logic signed [odpc_pkg::YY_W-1:0]     yy;
   logic [odpc_pkg::YEAR_W-1:0]          year;
   logic                                 leap;
   logic [odpc_pkg::DOY_W-1:0]           doy;
   logic [odpc_pkg::DOY_W-1:0]           offs;
   logic [odpc_pkg::DOY_W-1:0]           dom;
   logic [odpc_pkg::DOY_W-1:0]           mend;
   logic [odpc_pkg::MONTH_W-1:0]         month;
   logic                                 day_bad;

   function automatic logic is_digit(input logic [odpc_pkg::CHAR_W-1:0] ch);
      return (ch >= odpc_pkg::CHAR_ZERO) && (ch <= odpc_pkg::CHAR_NINE);
   endfunction

   always_comb begin
      format_bad = (code.chars_present < odpc_pkg::FULL_CODE_LEN) ||
                   !is_digit(code.year_digit_char) ||
                   !is_digit(code.day_hundreds_char) ||
                   !is_digit(code.day_tens_char) ||
                   !is_digit(code.day_ones_char);

      d = code.year_digit_char[3:0];

      // current year mod 10 by reciprocal multiply, exact for every 7-bit current year
      prod = 14'({7'd0, cyear} * 14'd103);
      q    = prod[13:10];
      t    = 4'(cyear - 7'({3'd0, q} * 7'd10));

      c_s = signed'({2'b00, cyear});
      d_s = signed'({5'd0, d});
      t_s = signed'({5'd0, t});

      priority if (d == t) begin
         yy = c_s;
      end else if (d == 4'd0 && t == 4'd9) begin
         yy = c_s + 9'sd1;
      end else if (d == 4'd9 && t == 4'd0) begin
         yy = c_s - 9'sd1;
      end else if (d < t) begin
         yy = c_s - t_s + d_s;
      end else if (d == t + 4'd1) begin
         yy = c_s + 9'sd1;
      end else begin
         yy = c_s - 9'sd10 + d_s - t_s;
      end

      year = ((yy >= odpc_pkg::PIVOT_YY) ? odpc_pkg::CENTURY_19 : odpc_pkg::CENTURY_20) +
             odpc_pkg::YEAR_W'(yy);
      // both century bases are multiples of four and 2000 is the only century
      // year in range, so leap follows yy alone
      leap = (yy[1:0] == 2'b00);

      doy = odpc_pkg::DOY_W'(code.day_hundreds_char[3:0]) * 10'd100 +
            odpc_pkg::DOY_W'(code.day_tens_char[3:0]) * 10'd10 +
            odpc_pkg::DOY_W'(code.day_ones_char[3:0]);

      // find the last month end below the day of year
      month = odpc_pkg::MONTH_W'(1);
      offs  = '0;
      for (int i = 0; i < odpc_pkg::NUM_MONTHS - 1; i++) begin
         mend = odpc_pkg::MONTH_END[i] +
                odpc_pkg::DOY_W'((i >= 1) && leap);
         if (doy > mend) begin
            month = odpc_pkg::MONTH_W'(i + 2);
            offs  = mend;
         end
      end
      dom = doy - offs;

      day_bad = (doy == '0) ||
                (doy > odpc_pkg::DAYS_COMMON_YEAR + odpc_pkg::DOY_W'(leap));

      priority if (format_bad) begin
         result = '{odpc_pkg::STATUS_FORMAT, '0, '0, '0};
      end else if (day_bad) begin
         result = '{odpc_pkg::STATUS_DAY, '0, '0, '0};
      end else begin
         result = '{odpc_pkg::STATUS_OK, year, month, dom[odpc_pkg::DOM_W-1:0]};
      end
   end

endmodule
`default_nettype wire
